// ----- src/mm4_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

   localparam int DIM     = 4;
   localparam int ELEM_W  = 32;
   localparam int ROW_W   = 2;
   localparam int PROD_W  = 2 * ELEM_W;
   localparam int PAIR_W  = PROD_W + 1;
   localparam int SUM_W   = PROD_W + 2;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_LOAD_A   = 2'd0;
   localparam logic [1:0] REQ_LOAD_B   = 2'd1;
   localparam logic [1:0] REQ_MULTIPLY = 2'd2;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DIM - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic [ROW_W-1:0] wr_row;
      logic             issue;
      logic [ROW_W-1:0] issue_row;
   } mm4_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic last_out;
   } mm4_status_type;

endpackage

// ----- src/matrix_multiply_4x4.sv -----
// Top level of the 4x4 signed fixed-point matrix multiplier.
//
// The block holds two 4x4 matrices, A and B, of signed fixed-point elements
// with FRAC_BITS fraction bits; both reset to the identity matrix. An item is
// accepted when start is high and busy is low. A load item (req_type 0 for A,
// 1 for B) writes one row, selected by req_row_index, in the cycle it is
// accepted and leaves busy low, so loads can follow one another every cycle.
// A multiply item (req_type 2) raises busy until its last row is out and
// produces four result items, rows 0 to 3 of A times B in order, on
// consecutive cycles; rsp_valid marks each one and rsp_last_row marks row 3.
// The receiver cannot stall: each result is present for exactly one cycle
// and must be taken then. The delay to the first result comes from the
// product pipeline (sixteen 32x32 multiplier lanes that handle one product
// row per cycle, a two-level adder tree and the shift-and-saturate stage)
// with its product, pair, sum and result registers. Each element is the exact
// sum of four 64-bit products, shifted right arithmetically by FRAC_BITS and
// clamped to the signed 32-bit range; rsp_row_saturated is set when any
// element of the row was clamped. req_type 3 is accepted and ignored.
module matrix_multiply_4x4 #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [mm4_pkg::ROW_W-1:0]           req_row_index,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   req_elem_0,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   req_elem_1,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   req_elem_2,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   req_elem_3,
   output logic                                rsp_valid,
   output logic [mm4_pkg::ROW_W-1:0]           rsp_out_row,
   output logic signed [mm4_pkg::ELEM_W-1:0]   rsp_prod_0,
   output logic signed [mm4_pkg::ELEM_W-1:0]   rsp_prod_1,
   output logic signed [mm4_pkg::ELEM_W-1:0]   rsp_prod_2,
   output logic signed [mm4_pkg::ELEM_W-1:0]   rsp_prod_3,
   output logic                                rsp_row_saturated,
   output logic                                rsp_last_row
);

   // Commands carry store writes and row issues; status reports the last row out.
   mm4_pkg::mm4_cmd_type    cmd;
   mm4_pkg::mm4_status_type status;

   mm4_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_type      (req_type),
      .req_row_index (req_row_index),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   mm4_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_elem_0        (req_elem_0),
      .req_elem_1        (req_elem_1),
      .req_elem_2        (req_elem_2),
      .req_elem_3        (req_elem_3),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_prod_0        (rsp_prod_0),
      .rsp_prod_1        (rsp_prod_1),
      .rsp_prod_2        (rsp_prod_2),
      .rsp_prod_3        (rsp_prod_3),
      .rsp_row_saturated (rsp_row_saturated),
      .rsp_last_row      (rsp_last_row)
   );

endmodule

// ----- src/mm4_ctrl.sv -----
// Controller state machine: accepts items, issues product rows, tracks busy.
module mm4_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_type,
   input  logic [mm4_pkg::ROW_W-1:0] req_row_index,
   input  mm4_pkg::mm4_status_type status,
   output logic                   busy,
   output mm4_pkg::mm4_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } ctl_state_type;

   ctl_state_type                 state_ff, state_in;
   logic [mm4_pkg::ROW_W-1:0]     cnt_ff, cnt_in;
   logic                          accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == mm4_pkg::REQ_MULTIPLY)) begin
               state_in = ST_ISSUE;
               cnt_in   = '0;
            end
         end
         ST_ISSUE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mm4_pkg::LAST_ROW) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.last_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.wr_a      = accept && (req_type == mm4_pkg::REQ_LOAD_A);
      cmd.wr_b      = accept && (req_type == mm4_pkg::REQ_LOAD_B);
      cmd.wr_row    = req_row_index;
      cmd.issue     = (state_ff == ST_ISSUE);
      cmd.issue_row = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // A multiply starts issuing at row zero in the very next cycle.
   a_mul_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == mm4_pkg::REQ_MULTIPLY))
      |=> (state_ff == ST_ISSUE) && (cnt_ff == '0))
      else $error("multiply did not start issuing at row zero");

   // Stores are never written while a product is being read out of them.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.wr_a && !cmd.wr_b)
      else $error("store written while busy");

   // Issuing covers exactly four rows, then the pipeline drains.
   a_issue_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) && (cnt_ff == mm4_pkg::LAST_ROW) |=> (state_ff == ST_DRAIN))
      else $error("issue phase did not end after the last row");

endmodule

// ----- src/mm4_datapath.sv -----
// Datapath: matrix stores, 16 multiplier lanes, adder tree and saturation stage.
module mm4_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mm4_pkg::mm4_cmd_type                  cmd,
   input  logic signed [mm4_pkg::ELEM_W-1:0]     req_elem_0,
   input  logic signed [mm4_pkg::ELEM_W-1:0]     req_elem_1,
   input  logic signed [mm4_pkg::ELEM_W-1:0]     req_elem_2,
   input  logic signed [mm4_pkg::ELEM_W-1:0]     req_elem_3,
   output mm4_pkg::mm4_status_type               status,
   output logic                                  rsp_valid,
   output logic [mm4_pkg::ROW_W-1:0]             rsp_out_row,
   output logic signed [mm4_pkg::ELEM_W-1:0]     rsp_prod_0,
   output logic signed [mm4_pkg::ELEM_W-1:0]     rsp_prod_1,
   output logic signed [mm4_pkg::ELEM_W-1:0]     rsp_prod_2,
   output logic signed [mm4_pkg::ELEM_W-1:0]     rsp_prod_3,
   output logic                                  rsp_row_saturated,
   output logic                                  rsp_last_row
);

   localparam int DIM    = mm4_pkg::DIM;
   localparam int EW     = mm4_pkg::ELEM_W;
   localparam int RW     = mm4_pkg::ROW_W;
   localparam int PW     = mm4_pkg::PROD_W;
   localparam int QW     = mm4_pkg::PAIR_W;
   localparam int SW     = mm4_pkg::SUM_W;
   localparam logic signed [EW-1:0] ONE_Q   = EW'(64'd1 << FRAC_BITS);
   localparam logic signed [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic signed [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

   logic signed [EW-1:0] a_ff [DIM][DIM];
   logic signed [EW-1:0] a_in [DIM][DIM];
   logic signed [EW-1:0] b_ff [DIM][DIM];
   logic signed [EW-1:0] b_in [DIM][DIM];
   logic signed [EW-1:0] wr_elem [DIM];

   logic signed [PW-1:0] prod_ff [DIM][DIM];
   logic signed [PW-1:0] prod_in [DIM][DIM];
   logic signed [QW-1:0] pair_ff [DIM][2];
   logic signed [QW-1:0] pair_in [DIM][2];
   logic signed [SW-1:0] sum_ff  [DIM];
   logic signed [SW-1:0] sum_in  [DIM];
   logic signed [SW-1:0] shifted [DIM];
   logic signed [EW-1:0] res_in  [DIM];
   logic signed [EW-1:0] res_ff  [DIM];
   logic [DIM-1:0]       sat_in;

   logic          v1_ff, v2_ff, v3_ff, vo_ff;
   logic [RW-1:0] row1_ff, row2_ff, row3_ff, rowo_ff;
   logic          sato_ff;

   assign wr_elem[0] = req_elem_0;
   assign wr_elem[1] = req_elem_1;
   assign wr_elem[2] = req_elem_2;
   assign wr_elem[3] = req_elem_3;

   // Store updates: one whole row per load.
   always_comb begin
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            a_in[r][c] = a_ff[r][c];
            b_in[r][c] = b_ff[r][c];
            if (cmd.wr_a && (cmd.wr_row == RW'(r))) begin
               a_in[r][c] = wr_elem[c];
            end
            if (cmd.wr_b && (cmd.wr_row == RW'(r))) begin
               b_in[r][c] = wr_elem[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               a_ff[r][c] <= (r == c) ? ONE_Q : '0;
               b_ff[r][c] <= (r == c) ? ONE_Q : '0;
            end
         end
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // Stage 1: one product per (column, k) lane for the issued row of A.
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         for (int k = 0; k < DIM; k++) begin
            prod_in[c][k] = PW'(a_ff[cmd.issue_row][k]) * PW'(b_ff[k][c]);
         end
      end
   end

   // Stage 2 and 3: two-level adder tree per column.
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         pair_in[c][0] = QW'(prod_ff[c][0]) + QW'(prod_ff[c][1]);
         pair_in[c][1] = QW'(prod_ff[c][2]) + QW'(prod_ff[c][3]);
         sum_in[c]     = SW'(pair_ff[c][0]) + SW'(pair_ff[c][1]);
      end
   end

   // Stage 4: floor shift, then clamp to the 32-bit signed range.
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         shifted[c] = sum_ff[c] >>> FRAC_BITS;
         if ((shifted[c][SW-1:EW-1] == '0) || (shifted[c][SW-1:EW-1] == '1)) begin
            res_in[c] = shifted[c][EW-1:0];
            sat_in[c] = 1'b0;
         end else begin
            res_in[c] = shifted[c][SW-1] ? SAT_MIN : SAT_MAX;
            sat_in[c] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      pair_ff <= pair_in;
      sum_ff  <= sum_in;
      res_ff  <= res_in;
      row1_ff <= cmd.issue_row;
      row2_ff <= row1_ff;
      row3_ff <= row2_ff;
      rowo_ff <= row3_ff;
      sato_ff <= |sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   assign rsp_valid         = vo_ff;
   assign rsp_out_row       = rowo_ff;
   assign rsp_prod_0        = res_ff[0];
   assign rsp_prod_1        = res_ff[1];
   assign rsp_prod_2        = res_ff[2];
   assign rsp_prod_3        = res_ff[3];
   assign rsp_row_saturated = sato_ff;
   assign rsp_last_row      = (rowo_ff == mm4_pkg::LAST_ROW);
   assign status.last_out   = vo_ff && rsp_last_row;

   // Rows leave in order without gaps until the last one.
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_row
      |=> rsp_valid && (rsp_out_row == $past(rsp_out_row) + 2'd1))
      else $error("product rows out of order or interrupted");

   // An issued row reaches the output after the product, pair, sum and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> ##4 rsp_valid)
      else $error("issued row did not reach the output on time");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 4x4 signed fixed-point matrix multiplier.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   // The block's fraction width; the predictor shifts by the same amount.
   localparam int FRAC = 16;

   // Code 3 on req_type has no name in the package; the block accepts and drops it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 225;
   // A multiply keeps busy high until its last row is out, so the settle cycles
   // at the end cover any straggler.
   localparam int SETTLE_CYCLES = 24;
   // The slowest correct run is a few hundred items, each with its busy time and
   // idle gap; the limit is many times as long as that run.
   localparam int RUN_LIMIT_NS  = 4_000_000;

   localparam logic [31:0] Q_ONE = 32'h0001_0000;
   localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   // One item as the sender queues it, with its pacing attached. A set
   // drain_first holds the item back until no product row is outstanding.
   typedef struct packed {
      logic [1:0]                kind;
      logic [mm4_pkg::ROW_W-1:0] row;
      logic [31:0]               e0;
      logic [31:0]               e1;
      logic [31:0]               e2;
      logic [31:0]               e3;
      logic                      drain_first;
      logic [7:0]                idle_after;
   } load_or_mul_type;

   // One product row as the predictor expects it on the result ports.
   typedef struct packed {
      logic [mm4_pkg::ROW_W-1:0] row;
      logic [31:0]               p0;
      logic [31:0]               p1;
      logic [31:0]               p2;
      logic [31:0]               p3;
      logic                      saturated;
      logic                      last;
   } product_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [1:0]                        req_type = mm4_pkg::REQ_LOAD_A;
   logic [mm4_pkg::ROW_W-1:0]         req_row_index = '0;
   logic signed [mm4_pkg::ELEM_W-1:0] req_elem_0 = '0;
   logic signed [mm4_pkg::ELEM_W-1:0] req_elem_1 = '0;
   logic signed [mm4_pkg::ELEM_W-1:0] req_elem_2 = '0;
   logic signed [mm4_pkg::ELEM_W-1:0] req_elem_3 = '0;
   logic                              rsp_valid;
   logic [mm4_pkg::ROW_W-1:0]         rsp_out_row;
   logic signed [mm4_pkg::ELEM_W-1:0] rsp_prod_0;
   logic signed [mm4_pkg::ELEM_W-1:0] rsp_prod_1;
   logic signed [mm4_pkg::ELEM_W-1:0] rsp_prod_2;
   logic signed [mm4_pkg::ELEM_W-1:0] rsp_prod_3;
   logic                              rsp_row_saturated;
   logic                              rsp_last_row;

   // Items waiting for the driver, and product rows waiting for the block.
   load_or_mul_type pending_items [$];
   product_row_type expected_rows [$];

   // The testbench's own copy of the two matrix stores, row-major.
   logic signed [31:0] mat_a [mm4_pkg::DIM*mm4_pkg::DIM];
   logic signed [31:0] mat_b [mm4_pkg::DIM*mm4_pkg::DIM];

   logic            took_item = 1'b0;
   int              idle_left = 0;
   load_or_mul_type next_item;

   int error_count     = 0;
   int items_taken     = 0;
   int multiplies      = 0;
   int rows_checked    = 0;
   int saturated_rows  = 0;

   matrix_multiply_4x4 #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_row_index     (req_row_index),
      .req_elem_0        (req_elem_0),
      .req_elem_1        (req_elem_1),
      .req_elem_2        (req_elem_2),
      .req_elem_3        (req_elem_3),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_prod_0        (rsp_prod_0),
      .rsp_prod_1        (rsp_prod_1),
      .rsp_prod_2        (rsp_prod_2),
      .rsp_prod_3        (rsp_prod_3),
      .rsp_row_saturated (rsp_row_saturated),
      .rsp_last_row      (rsp_last_row)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // One element of A times B: the exact sum of four products, shifted right
   // arithmetically (so it rounds toward minus infinity) and clamped to 32 bits.
   // The sum needs 66 bits; after the shift it fits in 32 only when bits 65
   // down to 31 all agree. Bit 32 of the return value flags a clamp.
   function automatic logic [32:0] product_element(int r, int c);
      logic signed [65:0] acc;
      logic signed [65:0] lhs;
      logic signed [65:0] rhs;
      logic signed [65:0] shifted;
      int k;
      acc = '0;
      for (k = 0; k < mm4_pkg::DIM; k++) begin
         lhs = mat_a[r*mm4_pkg::DIM + k];
         rhs = mat_b[k*mm4_pkg::DIM + c];
         acc = acc + lhs * rhs;
      end
      shifted = acc >>> FRAC;
      if (&shifted[65:31] || ~|shifted[65:31])
         return {1'b0, shifted[31:0]};
      return {1'b1, shifted[65] ? Q_MIN : Q_MAX};
   endfunction

   // Applies one accepted item to the store copies; a multiply queues the four
   // product rows it is expected to produce, top to bottom.
   function automatic void predict_item(logic [1:0] kind,
                                        logic [mm4_pkg::ROW_W-1:0] row,
                                        logic [31:0] e0, logic [31:0] e1,
                                        logic [31:0] e2, logic [31:0] e3);
      product_row_type pr;
      logic [32:0]     el [mm4_pkg::DIM];
      int r;
      int c;
      case (kind)
         mm4_pkg::REQ_LOAD_A: begin
            mat_a[row*mm4_pkg::DIM + 0] = e0;
            mat_a[row*mm4_pkg::DIM + 1] = e1;
            mat_a[row*mm4_pkg::DIM + 2] = e2;
            mat_a[row*mm4_pkg::DIM + 3] = e3;
         end
         mm4_pkg::REQ_LOAD_B: begin
            mat_b[row*mm4_pkg::DIM + 0] = e0;
            mat_b[row*mm4_pkg::DIM + 1] = e1;
            mat_b[row*mm4_pkg::DIM + 2] = e2;
            mat_b[row*mm4_pkg::DIM + 3] = e3;
         end
         mm4_pkg::REQ_MULTIPLY: begin
            for (r = 0; r < mm4_pkg::DIM; r++) begin
               for (c = 0; c < mm4_pkg::DIM; c++)
                  el[c] = product_element(r, c);
               pr.row       = mm4_pkg::ROW_W'(r);
               pr.p0        = el[0][31:0];
               pr.p1        = el[1][31:0];
               pr.p2        = el[2][31:0];
               pr.p3        = el[3][31:0];
               pr.saturated = el[0][32] | el[1][32] | el[2][32] | el[3][32];
               pr.last      = (mm4_pkg::ROW_W'(r) == mm4_pkg::LAST_ROW);
               expected_rows.push_back(pr);
            end
         end
         default: begin
            // The unused code changes nothing and produces nothing.
         end
      endcase
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %08h, got %08h", name, want, got);
         error_count++;
      end
   endtask

   task automatic queue_item(logic [1:0] kind, logic [mm4_pkg::ROW_W-1:0] row,
                             logic [31:0] e0, logic [31:0] e1,
                             logic [31:0] e2, logic [31:0] e3,
                             logic drain_first, logic [7:0] idle_after);
      load_or_mul_type it;
      it.kind        = kind;
      it.row         = row;
      it.e0          = e0;
      it.e1          = e1;
      it.e2          = e2;
      it.e3          = e3;
      it.drain_first = drain_first;
      it.idle_after  = idle_after;
      pending_items.push_back(it);
   endtask

   // Elements are mostly small so that most products stay in range, with a
   // share of wide values and of the boundary values that force clamping.
   function automatic logic [31:0] pick_elem();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      if (pick < 70)
         return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      if (pick < 85)
         return $urandom;
      case ($urandom_range(0, 6))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hFFFF_FFFF;
         3: return Q_ONE;
         4: return -Q_ONE;
         5: return Q_MAX;
         default: return Q_MIN;
      endcase
   endfunction

   // Idle cycles after an item: mostly none, often a few, now and then many.
   function automatic logic [7:0] pick_idle();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         return 8'd0;
      if (pick < 93)
         return 8'($urandom_range(1, 3));
      return 8'($urandom_range(10, 45));
   endfunction

   // Sampling side. At each rising edge the result ports are checked against
   // the oldest expected row, and an item that the block takes at this edge is
   // run through the predictor. Both look at values from before the edge:
   // the block updates its outputs through nonblocking assignments and the
   // driver only moves the inputs at falling edges.
   always @(posedge clock) begin
      product_row_type want;
      if (reset) begin
         took_item <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_rows.size() == 0) begin
               $error("product row %0d arrived with no row expected", rsp_out_row);
               error_count++;
            end else begin
               want = expected_rows.pop_front();
               check_field("out_row", 32'(want.row), 32'(rsp_out_row));
               check_field("prod_0", want.p0, rsp_prod_0);
               check_field("prod_1", want.p1, rsp_prod_1);
               check_field("prod_2", want.p2, rsp_prod_2);
               check_field("prod_3", want.p3, rsp_prod_3);
               check_field("row_saturated", 32'(want.saturated), 32'(rsp_row_saturated));
               check_field("last_row", 32'(want.last), 32'(rsp_last_row));
               rows_checked++;
               if (want.saturated)
                  saturated_rows++;
            end
         end
         if (start && !busy) begin
            predict_item(req_type, req_row_index, req_elem_0, req_elem_1,
                         req_elem_2, req_elem_3);
            items_taken++;
            if (req_type == mm4_pkg::REQ_MULTIPLY)
               multiplies++;
         end
         took_item <= start && !busy;
      end
   end

   // Driving side. An item stays on the ports with start high until the
   // block takes it. After that the driver either idles for the item's gap,
   // holds off for a draining item until no rows are outstanding, or puts the
   // next item up straight away so start simply stays high.
   always @(negedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else if (start && !took_item) begin
         // The block is still busy; keep the item where it is.
      end else if (idle_left != 0) begin
         start     <= 1'b0;
         idle_left <= idle_left - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain_first && expected_rows.size() != 0)) begin
         start <= 1'b0;
      end else begin
         next_item     = pending_items.pop_front();
         req_type      <= next_item.kind;
         req_row_index <= next_item.row;
         req_elem_0    <= next_item.e0;
         req_elem_1    <= next_item.e1;
         req_elem_2    <= next_item.e2;
         req_elem_3    <= next_item.e3;
         idle_left     <= int'(next_item.idle_after);
         start         <= 1'b1;
      end
   end

   // Stimulus and the end of the run.
   initial begin
      int i;
      int counted;
      int pick;
      logic [1:0] kind;

      // Both stores come out of reset as the identity matrix.
      for (i = 0; i < mm4_pkg::DIM*mm4_pkg::DIM; i++) begin
         mat_a[i] = (i % (mm4_pkg::DIM + 1) == 0) ? Q_ONE : '0;
         mat_b[i] = (i % (mm4_pkg::DIM + 1) == 0) ? Q_ONE : '0;
      end

      // Directed part, sent back to back. First the reset contents: I times I.
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd0, '0, '0, '0, '0, 1'b0, 8'd0);
      // Largest positive elements everywhere: the sums run past even the
      // 64-bit range and every element clamps high.
      for (i = 0; i < mm4_pkg::DIM; i++)
         queue_item(mm4_pkg::REQ_LOAD_A, mm4_pkg::ROW_W'(i), Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                    1'b0, 8'd0);
      for (i = 0; i < mm4_pkg::DIM; i++)
         queue_item(mm4_pkg::REQ_LOAD_B, mm4_pkg::ROW_W'(i), Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                    1'b0, 8'd0);
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd3, '0, '0, '0, '0, 1'b0, 8'd0);
      // Most negative B against most positive A clamps low.
      for (i = 0; i < mm4_pkg::DIM; i++)
         queue_item(mm4_pkg::REQ_LOAD_B, mm4_pkg::ROW_W'(i), Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                    1'b0, 8'd0);
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd0, '0, '0, '0, '0, 1'b0, 8'd0);
      // Most negative times most negative is the largest product of all.
      for (i = 0; i < mm4_pkg::DIM; i++)
         queue_item(mm4_pkg::REQ_LOAD_A, mm4_pkg::ROW_W'(i), Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                    1'b0, 8'd0);
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd1, '0, '0, '0, '0, 1'b0, 8'd0);
      // Row 2 of A picks out row 0 of B at the smallest scale, so the shift
      // has to round -1 and -3 down to -1 and 1 and 3 down to 0.
      queue_item(mm4_pkg::REQ_LOAD_B, 2'd0, 32'hFFFF_FFFF, 32'h1, 32'h3, 32'hFFFF_FFFD,
                 1'b0, 8'd0);
      queue_item(mm4_pkg::REQ_LOAD_A, 2'd2, 32'h1, '0, '0, '0, 1'b0, 8'd0);
      // The unused code, looking like a load of A row 1; nothing may change.
      queue_item(REQ_UNUSED, 2'd1, Q_MAX, Q_ONE, 32'h0, Q_MAX, 1'b0, 8'd0);
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd2, '0, '0, '0, '0, 1'b0, 8'd0);

      // Random part: loads and multiplies with random pacing and a little
      // noise from the unused code, which does not count toward the total.
      // Every 64th item waits for all rows to come back, and one stretch runs
      // with no idling at all.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 36)
            kind = mm4_pkg::REQ_LOAD_A;
         else if (pick < 72)
            kind = mm4_pkg::REQ_LOAD_B;
         else if (pick < 95)
            kind = mm4_pkg::REQ_MULTIPLY;
         else
            kind = REQ_UNUSED;
         queue_item(kind, mm4_pkg::ROW_W'($urandom_range(0, mm4_pkg::DIM - 1)),
                    pick_elem(), pick_elem(), pick_elem(), pick_elem(),
                    (counted % 64 == 0) && kind != REQ_UNUSED,
                    (counted >= 100 && counted < 140) ? 8'd0 : pick_idle());
         if (kind != REQ_UNUSED)
            counted++;
      end
      // Close with a multiply so the final store contents are read out.
      queue_item(mm4_pkg::REQ_MULTIPLY, 2'd0, '0, '0, '0, '0, 1'b0, 8'd0);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Wait for the last item to be taken and its rows to come back, then
      // let the pipeline run on a little in case it sends anything extra.
      while (pending_items.size() != 0 || start)
         @(posedge clock);
      while (expected_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d items, %0d of them multiplies, and checked %0d rows.",
               items_taken, multiplies, rows_checked);
      $display("%0d of the checked rows were clamped; %0d mismatches were seen.",
               saturated_rows, error_count);
      if (error_count == 0 && expected_rows.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog against a hung handshake or missing rows.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d items pending and %0d rows outstanding.",
               pending_items.size(), expected_rows.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
